### rtl/rational_arithmetic_unit_top_defines.svh
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/rau_pkg.sv
package rau_pkg;
   localparam int unsigned CmdWidth = 3;
   localparam int unsigned DataWidth = 32;
   localparam int unsigned MagWidth = 64;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2, CMD_DIV = 3'd3,
      CMD_GT = 3'd4, CMD_LT = 3'd5, CMD_RED = 3'd6, CMD_NOP = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_GCD_ZERO = 2'd1, ST_OVERFLOW = 2'd2, ST_SPARE = 2'd3
   } status_type;

   typedef struct packed {
      logic [CmdWidth-1:0] cmd;
      logic [DataWidth-1:0] a_num;
      logic [DataWidth-1:0] a_den;
      logic [DataWidth-1:0] b_num;
      logic [DataWidth-1:0] b_den;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] res_num;
      logic [DataWidth-1:0] res_den;
      logic cmp_true;
      logic [1:0] status;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      cmd_type cmd;
      logic [DataWidth-1:0] a_num;
      logic [DataWidth-1:0] a_den;
      logic [DataWidth-1:0] b_num;
      logic [DataWidth-1:0] b_den;
   } job_type;
endpackage

### rtl/rau_if.sv
interface rau_req_if;
   import rau_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rau_rsp_if;
   import rau_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/rau_front.sv
module rau_front #(
   parameter int unsigned FIELD_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   rau_req_if.sink req,
   output logic job_valid,
   input  logic job_ready,
   output rau_pkg::job_type job
);
   import rau_pkg::*;

   // two entry queue
   job_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic wr_ff, wr_in, rd_ff, rd_in;
   job_type j;
   logic push, pop;

   function automatic logic [DataWidth-1:0] sxf(input logic [DataWidth-1:0] x);
      logic [DataWidth-1:0] r;
      r = x;
      for (int i = FIELD_WIDTH; i < DataWidth; i++) r[i] = x[FIELD_WIDTH-1];
      return r;
   endfunction

   always_comb begin
      j.cmd = cmd_type'(req.data.cmd);
      j.a_num = sxf(req.data.a_num);
      j.a_den = sxf(req.data.a_den);
      j.b_num = sxf(req.data.b_num);
      j.b_den = sxf(req.data.b_den);
      if (j.cmd == CMD_RED) begin
         j.b_num = '0;
         j.b_den = '0;
      end
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_ready;
   assign job = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      wr_in = wr_ff ^ push;
      rd_in = rd_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
      if (push) q_ff[wr_ff] <= j;
   end
endmodule

### rtl/rau_back.sv
module rau_back #(
   parameter int unsigned FIELD_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  rau_pkg::job_type job,
   rau_rsp_if.source rsp
);
   import rau_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001, S_MUL1 = 9'b000000010, S_MUL2 = 9'b000000100,
      S_MUL3 = 9'b000001000, S_SUM = 9'b000010000, S_GCD = 9'b000100000,
      S_DIV = 9'b001000000, S_FIN = 9'b010000000, S_OUT = 9'b100000000
   } state_type;

   localparam int unsigned W = MagWidth;
   localparam int unsigned CW = $clog2(W + 1);
   localparam int unsigned SW = 2 * DataWidth + 1;

   state_type st_ff, st_in;
   cmd_type cmd_ff;
   logic signed [DataWidth-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [2*DataWidth-1:0] p0_ff, p1_ff, p2_ff;
   logic nneg_ff, dneg_ff;
   logic [W-1:0] nmag_ff, dmag_ff;
   // gcd by remainder iteration, shared restoring divider
   logic [W-1:0] ga_ff, gb_ff, g_ff;
   logic [W-1:0] dq_ff, drem_ff, ddiv_ff;
   logic [CW-1:0] dcnt_ff;
   logic [1:0] phase_ff;
   logic [W-1:0] qn_ff;
   logic cmp_ff;
   rsp_type out_ff;
   logic outv_ff;

   logic signed [DataWidth-1:0] ma, mb;
   logic signed [2*DataWidth-1:0] prod;
   logic [W:0] trial;
   logic [W-1:0] rem_sh;
   logic [W-1:0] half;
   logic fitn, fitd;
   // one bit of headroom so the sum of two extreme products keeps its sign
   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] nv;
   logic [W-1:0] nv_mag, p1_mag, an_mag, ad_mag;
   logic is_cmp;
   logic out_go;
   rsp_type rsp_next;

   assign job_ready = st_ff == S_IDLE;
   assign rsp.valid = outv_ff;
   assign rsp.data = out_ff;
   assign half = W'(1) << (FIELD_WIDTH - 1);

   // one multiplier, one product per cycle
   always_comb begin
      unique case (st_ff)
         S_MUL1: begin
            ma = an_ff;
            mb = (cmd_ff == CMD_MUL) ? bn_ff : bd_ff;
         end
         S_MUL2: begin
            ma = ad_ff;
            mb = (cmd_ff == CMD_DIV) ? bn_ff : bd_ff;
         end
         S_MUL3: begin
            ma = bn_ff;
            mb = ad_ff;
         end
         default: begin
            ma = an_ff;
            mb = bd_ff;
         end
      endcase
   end
   assign prod = ma * mb;
   assign sum = (cmd_ff == CMD_SUB) ? SW'(p0_ff) - SW'(p2_ff) : SW'(p0_ff) + SW'(p2_ff);
   assign nv = (cmd_ff == CMD_MUL || cmd_ff == CMD_DIV) ? SW'(p0_ff) : sum;
   assign nv_mag = nv[SW-1] ? W'(-nv) : W'(nv);
   assign p1_mag = p1_ff[W-1] ? W'(-p1_ff) : W'(p1_ff);
   assign an_mag = an_ff[DataWidth-1] ? -W'(an_ff) : W'(an_ff);
   assign ad_mag = ad_ff[DataWidth-1] ? -W'(ad_ff) : W'(ad_ff);
   assign rem_sh = {drem_ff[W-2:0], dq_ff[W-1]};
   assign trial = {drem_ff, dq_ff[W-1]} - {1'b0, ddiv_ff};
   assign fitn = nneg_ff ? (nmag_ff <= half) : (nmag_ff < half);
   assign fitd = dneg_ff ? (dmag_ff <= half) : (dmag_ff < half);
   assign is_cmp = (cmd_ff == CMD_GT) || (cmd_ff == CMD_LT) || (cmd_ff == CMD_NOP);
   assign out_go = (st_ff == S_OUT) && (!outv_ff || rsp.ready);

   // result item, built only when the output register is free
   always_comb begin
      rsp_next = '0;
      if (is_cmp) begin
         rsp_next.cmp_true = cmp_ff;
      end else if (g_ff == '0) begin
         rsp_next.status = ST_GCD_ZERO;
      end else if (!fitn || !fitd) begin
         rsp_next.status = ST_OVERFLOW;
      end else begin
         rsp_next.res_num = nneg_ff ? DataWidth'(-nmag_ff) : DataWidth'(nmag_ff);
         rsp_next.res_den = dneg_ff ? DataWidth'(-dmag_ff) : DataWidth'(dmag_ff);
      end
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (job_valid) st_in = S_MUL1;
         S_MUL1: st_in = S_MUL2;
         S_MUL2: st_in = S_MUL3;
         S_MUL3: st_in = S_SUM;
         S_SUM: begin
            if (is_cmp) st_in = S_OUT;
            else st_in = S_GCD;
         end
         S_GCD: begin
            if (dcnt_ff == '0 && gb_ff == '0) st_in = S_DIV;
         end
         S_DIV: begin
            if (phase_ff == 2'd2 && dcnt_ff == '0) st_in = S_FIN;
         end
         S_FIN: st_in = S_OUT;
         S_OUT: if (out_go) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         outv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (out_go) outv_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) outv_ff <= 1'b0;
      end
      unique case (st_ff)
         S_IDLE: begin
            cmd_ff <= job.cmd;
            an_ff <= job.a_num;
            ad_ff <= job.a_den;
            bn_ff <= job.b_num;
            bd_ff <= job.b_den;
         end
         S_MUL1: p0_ff <= prod;       // numerator product or a_num * b_den
         S_MUL2: p1_ff <= prod;       // denominator product
         S_MUL3: p2_ff <= prod;       // b_num * a_den
         S_SUM: begin
            if (cmd_ff == CMD_RED) begin
               nneg_ff <= an_ff[DataWidth-1];
               nmag_ff <= an_mag;
               dneg_ff <= ad_ff[DataWidth-1];
               dmag_ff <= ad_mag;
               ga_ff <= an_mag;
               gb_ff <= ad_mag;
            end else begin
               nneg_ff <= nv[SW-1];
               nmag_ff <= nv_mag;
               dneg_ff <= p1_ff[W-1];
               dmag_ff <= p1_mag;
               ga_ff <= nv_mag;
               gb_ff <= p1_mag;
            end
            dcnt_ff <= '0;
            phase_ff <= 2'd0;
            cmp_ff <= (cmd_ff == CMD_GT) ? (p0_ff > p2_ff)
                    : (cmd_ff == CMD_LT) ? (p0_ff < p2_ff) : 1'b0;
         end
         S_GCD: begin
            if (dcnt_ff == '0) begin
               if (gb_ff != '0) begin
                  dq_ff <= ga_ff;
                  drem_ff <= '0;
                  ddiv_ff <= gb_ff;
                  dcnt_ff <= CW'(W);
               end else begin
                  g_ff <= ga_ff;
                  dq_ff <= nmag_ff;
                  drem_ff <= '0;
                  ddiv_ff <= ga_ff;
                  dcnt_ff <= CW'(W);
                  phase_ff <= 2'd1;
               end
            end else begin
               dq_ff <= {dq_ff[W-2:0], ~trial[W]};
               drem_ff <= trial[W] ? rem_sh : trial[W-1:0];
               dcnt_ff <= dcnt_ff - 1'b1;
               if (dcnt_ff == CW'(1)) begin
                  ga_ff <= gb_ff;
                  gb_ff <= trial[W] ? rem_sh : trial[W-1:0];
               end
            end
         end
         S_DIV: begin
            if (g_ff == '0) begin
               phase_ff <= 2'd2;
               dcnt_ff <= '0;
            end else if (dcnt_ff != '0) begin
               dq_ff <= {dq_ff[W-2:0], ~trial[W]};
               drem_ff <= trial[W] ? rem_sh : trial[W-1:0];
               dcnt_ff <= dcnt_ff - 1'b1;
            end else if (phase_ff == 2'd1) begin
               qn_ff <= dq_ff;
               dq_ff <= dmag_ff;
               drem_ff <= '0;
               dcnt_ff <= CW'(W);
               phase_ff <= 2'd2;
            end
         end
         S_FIN: begin
            if (g_ff != '0) begin
               nmag_ff <= qn_ff;
               dmag_ff <= dq_ff;
            end
         end
         S_OUT: begin
            if (out_go) out_ff <= rsp_next;
         end
         default: begin
         end
      endcase
   end
endmodule

### rtl/rational_arithmetic_unit_top.sv
// rational arithmetic unit: takes an item with an operation code and two signed fractions
// and returns one item. a front stage sign-extends the fields from FIELD_WIDTH and holds
// up to two items in a queue; the back stage forms the three cross products one after
// another on a single 32x32 multiplier, takes the gcd by repeated remainders and divides
// both values by it, all on one shared restoring divider at one quotient bit per cycle.
// items are handled one at a time: the back stage takes no new item until it has passed
// its result to the output register, and compares and the unused code skip the gcd and
// the divisions; a result that
// is held back stalls the back stage and then the queue
`include "rational_arithmetic_unit_top_defines.svh"
module rational_arithmetic_unit_top #(
   parameter int unsigned FIELD_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   rau_req_if.sink req,
   rau_rsp_if.source rsp
);
   import rau_pkg::*;

   logic job_valid, job_ready;
   job_type job;
   logic rsp_stall, cmp_seen, cmp_clean, job_take;

   rau_front #(.FIELD_WIDTH(FIELD_WIDTH)) u_front (
      .clock, .reset, .req, .job_valid, .job_ready, .job
   );
   rau_back #(.FIELD_WIDTH(FIELD_WIDTH)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job, .rsp
   );

   assign rsp_stall = rsp.valid && !rsp.ready;
   assign cmp_seen = rsp.valid && rsp.data.cmp_true;
   assign cmp_clean = (rsp.data.res_num == '0) && (rsp.data.status == ST_OK);
   assign job_take = job_valid && job_ready;

   // a stalled result must not change
   `RAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp.data), "stalled item changed")
   // compare results carry no fraction
   `RAU_ASSERT_IMPL(a_cmp_zero, clock, reset, cmp_seen, cmp_clean, "compare with payload")
   // back stage is busy right after it takes a job
   `RAU_ASSERT_NEXT(a_job, clock, reset, job_take, !job_ready, "back stage took two jobs")
endmodule
